/* src/rqa_pkg.sv */
// Shared widths, codes and types for the recurrence line-length histogram block.
`default_nettype none

package rqa_pkg;

    localparam int ROW_W   = 32;
    localparam int SIZE_W  = 6;
    localparam int LEN_W   = 6;
    localparam int HIST_W  = 11;
    localparam int TDATA_W = 32;
    localparam int PAD_W   = TDATA_W - LEN_W - 2 * HIST_W;

    localparam logic [HIST_W-1:0] HIST_MAX = 11'd2047;

    localparam logic KIND_VERT = 1'b0;
    localparam logic KIND_DIAG = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_RUN_RD    = 8'b0000_0010,
        ST_RUN_UPD   = 8'b0000_0100,
        ST_BIN_UPD   = 8'b0000_1000,
        ST_EMIT_RDD  = 8'b0001_0000,
        ST_EMIT_RDV  = 8'b0010_0000,
        ST_EMIT_LOAD = 8'b0100_0000,
        ST_EMIT_WAIT = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic clear;
        logic wr_en;
    } mem_ctl_t;

endpackage

`default_nettype wire

/* src/rqa_step_unit.sv */
// Shared run and bin update unit: advances one run and saturates one histogram bin.
`default_nettype none

module rqa_step_unit
    import rqa_pkg::*;
#(
    parameter int MAX_SIZE = 32,
    parameter int CNT_W    = 6
)
(
    input  wire logic [CNT_W-1:0]  run_in,
    input  wire logic              rec_flag,
    input  wire logic              last_in,
    input  wire logic [HIST_W-1:0] bin_in,
    output logic [CNT_W-1:0]       run_out,
    output logic                   bump,
    output logic [CNT_W-1:0]       bump_len,
    output logic [HIST_W-1:0]      bin_out
);

    logic [CNT_W-1:0] run_inc;

    always_comb
    begin
        if (run_in < CNT_W'(MAX_SIZE))
        begin
            run_inc = run_in + CNT_W'(1);
        end
        else
        begin
            run_inc = run_in;
        end

        if (rec_flag)
        begin
            bump_len = run_inc;
            bump     = last_in;
            run_out  = last_in ? '0 : run_inc;
        end
        else
        begin
            bump_len = run_in;
            bump     = (run_in != '0);
            run_out  = '0;
        end

        if (bin_in < HIST_MAX)
        begin
            bin_out = bin_in + HIST_W'(1);
        end
        else
        begin
            bin_out = bin_in;
        end
    end

endmodule

`default_nettype wire

/* src/rqa_vmem.sv */
// Single-write, single-read store with registered read and per-entry valid bits.
`default_nettype none

module rqa_vmem
    import rqa_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mem_ctl_t         ctl,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

/* src/recurrence_line_length_histogram_top.sv */
// Top level: row sequencer, run and histogram stores, and result output register.
`default_nettype none

// Takes a binary recurrence matrix one row per beat and builds the vertical and
// diagonal line-length histograms. Each row visits columns 0..n-1 in turn, and each
// column makes a vertical pass and a diagonal pass through the one shared update unit:
// each pass reads the run store (ST_RUN_RD), writes it back (ST_RUN_UPD) and, when a
// run ends, bumps its histogram bin (ST_BIN_UPD), serialised by the single read port of
// the run store and of the histogram store, both with registered reads. The last row is
// followed by n result beats, one per line length 1..n, each read from both histograms
// and held through any output stall; tlast marks length n. Histograms and runs clear
// after the last result and on every size write, so no clearing pass follows reset.
module recurrence_line_length_histogram_top
    import rqa_pkg::*;
#(
    parameter int MAX_SIZE = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [31:0] row_bits
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [5:0] line_length, [16:6] diagonal_count,
                                               // [27:17] vertical_count, [31:28] zero
    output logic                    m_tlast,   // last_bin
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [SIZE_W-1:0]  cfg_data   // matrix_size
);

    localparam int CNT_W      = $clog2(MAX_SIZE + 1);
    localparam int IDX_W      = $clog2(MAX_SIZE);
    localparam int RUN_DEPTH  = 3 * MAX_SIZE - 1;
    localparam int RUN_AW     = $clog2(RUN_DEPTH);
    localparam int HIST_AW    = IDX_W + 1;
    localparam int HIST_DEPTH = 2 ** HIST_AW;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [IDX_W-1:0]    row_cnt_reg, row_cnt_next;
    logic [IDX_W-1:0]    col_reg, col_next;
    logic                kind_reg, kind_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [HIST_AW-1:0]  bump_addr_reg;
    logic                m_valid_reg, m_valid_next;
    logic [HIST_W-1:0]   out_diag_reg;
    logic [HIST_W-1:0]   out_vert_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_last_reg;

    logic [CNT_W-1:0]    size_n;
    logic [CNT_W-1:0]    size_nm1;
    logic                last_row;
    logic                last_col;
    logic [CNT_W:0]      diag_sum;
    logic [RUN_AW-1:0]   run_addr;
    logic [ROW_W-1:0]    row_shift;
    logic                cur_flag;
    logic                cur_last;
    logic                s_accept;
    logic                m_accept;
    logic                cfg_accept;
    logic                clear_matrix;

    logic [CNT_W-1:0]    run_rd_data;
    logic [HIST_W-1:0]   hist_rd_data;
    logic [HIST_AW-1:0]  hist_rd_addr;
    logic [HIST_AW-1:0]  unit_bin_addr;
    logic [CNT_W-1:0]    unit_run;
    logic                unit_bump;
    logic [CNT_W-1:0]    unit_len;
    logic [HIST_W-1:0]   unit_bin;
    mem_ctl_t            run_ctl;
    mem_ctl_t            hist_ctl;

    always_comb
    begin
        if (size_reg == '0)
        begin
            size_n = CNT_W'(1);
        end
        else if ({1'b0, size_reg} > (SIZE_W + 1)'(MAX_SIZE))
        begin
            size_n = CNT_W'(MAX_SIZE);
        end
        else
        begin
            size_n = CNT_W'(size_reg);
        end
    end

    assign size_nm1  = size_n - CNT_W'(1);
    assign last_row  = (CNT_W'(row_cnt_reg) == size_nm1);
    assign last_col  = (CNT_W'(col_reg) == size_nm1);
    assign diag_sum  = (CNT_W + 1)'(row_cnt_reg) + (CNT_W + 1)'(size_nm1)
                     - (CNT_W + 1)'(col_reg);
    assign run_addr  = (kind_reg == KIND_DIAG)
                     ? RUN_AW'(MAX_SIZE) + RUN_AW'(diag_sum)
                     : RUN_AW'(col_reg);
    assign row_shift = row_reg >> col_reg;
    assign cur_flag  = row_shift[0];
    assign cur_last  = last_row || ((kind_reg == KIND_DIAG) && last_col);

    assign s_tready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign s_accept     = s_tvalid && s_tready;
    assign m_accept     = m_valid_reg && m_tready;
    assign cfg_accept   = cfg_valid && cfg_ready;
    assign clear_matrix = cfg_accept
                       || ((state_reg == ST_EMIT_WAIT) && m_accept && out_last_reg);

    assign unit_bin_addr = {kind_reg, IDX_W'(unit_len - CNT_W'(1))};

    always_comb
    begin
        case (state_reg)
            ST_EMIT_RDD: hist_rd_addr = {KIND_DIAG, IDX_W'(len_reg - CNT_W'(1))};
            ST_EMIT_RDV: hist_rd_addr = {KIND_VERT, IDX_W'(len_reg - CNT_W'(1))};
            default:     hist_rd_addr = unit_bin_addr;
        endcase
    end

    assign run_ctl.clear  = clear_matrix;
    assign run_ctl.wr_en  = (state_reg == ST_RUN_UPD);
    assign hist_ctl.clear = clear_matrix;
    assign hist_ctl.wr_en = (state_reg == ST_BIN_UPD);

    rqa_vmem #(
        .DEPTH (RUN_DEPTH),
        .WIDTH (CNT_W),
        .AW    (RUN_AW)
    ) u_run_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (run_ctl),
        .wr_addr (run_addr),
        .wr_data (unit_run),
        .rd_addr (run_addr),
        .rd_data (run_rd_data)
    );

    rqa_vmem #(
        .DEPTH (HIST_DEPTH),
        .WIDTH (HIST_W),
        .AW    (HIST_AW)
    ) u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hist_ctl),
        .wr_addr (bump_addr_reg),
        .wr_data (unit_bin),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    rqa_step_unit #(
        .MAX_SIZE (MAX_SIZE),
        .CNT_W    (CNT_W)
    ) u_step (
        .run_in   (run_rd_data),
        .rec_flag (cur_flag),
        .last_in  (cur_last),
        .bin_in   (hist_rd_data),
        .run_out  (unit_run),
        .bump     (unit_bump),
        .bump_len (unit_len),
        .bin_out  (unit_bin)
    );

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        col_next     = col_reg;
        kind_next    = kind_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    col_next   = '0;
                    kind_next  = KIND_VERT;
                    state_next = ST_RUN_RD;
                end
            end
            ST_RUN_RD:
            begin
                state_next = ST_RUN_UPD;
            end
            ST_RUN_UPD, ST_BIN_UPD:
            begin
                if ((state_reg == ST_RUN_UPD) && unit_bump)
                begin
                    state_next = ST_BIN_UPD;
                end
                else if (kind_reg == KIND_VERT)
                begin
                    kind_next  = KIND_DIAG;
                    state_next = ST_RUN_RD;
                end
                else
                begin
                    kind_next = KIND_VERT;
                    if (!last_col)
                    begin
                        col_next   = col_reg + IDX_W'(1);
                        state_next = ST_RUN_RD;
                    end
                    else if (last_row)
                    begin
                        len_next   = CNT_W'(1);
                        state_next = ST_EMIT_RDD;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + IDX_W'(1);
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RDD:
            begin
                state_next = ST_EMIT_RDV;
            end
            ST_EMIT_RDV:
            begin
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                m_valid_next = 1'b1;
                state_next   = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (m_accept)
                begin
                    m_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        row_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        len_next   = len_reg + CNT_W'(1);
                        state_next = ST_EMIT_RDD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_accept)
        begin
            row_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            size_reg    <= SIZE_W'(32);
            row_cnt_reg <= '0;
            col_reg     <= '0;
            kind_reg    <= KIND_VERT;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            col_reg     <= col_next;
            kind_reg    <= kind_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            if (cfg_accept)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            row_reg <= s_tdata[ROW_W-1:0];
        end
        if (state_reg == ST_RUN_UPD)
        begin
            bump_addr_reg <= unit_bin_addr;
        end
        if (state_reg == ST_EMIT_RDV)
        begin
            out_diag_reg <= hist_rd_data;
        end
        if (state_reg == ST_EMIT_LOAD)
        begin
            out_vert_reg <= hist_rd_data;
            out_len_reg  <= LEN_W'(len_reg);
            out_last_reg <= (len_reg == size_n);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_vert_reg, out_diag_reg, out_len_reg};

`ifndef SYNTHESIS
    a_valid_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (state_reg == ST_EMIT_WAIT))
        else $error("result valid outside the emit wait state");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(row_cnt_reg) < size_n)
        else $error("row counter beyond matrix size");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_RD || state_reg == ST_RUN_UPD || state_reg == ST_BIN_UPD)
        |-> CNT_W'(col_reg) < size_n)
        else $error("column index beyond matrix size");

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (len_reg != '0 && len_reg <= size_n))
        else $error("line length out of range");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_tready && out_last_reg) |=> (s_tready && !m_valid_reg))
        else $error("block not idle after final result");
`endif

endmodule

`default_nettype wire

/* tb/line_hist_checker.sv */
// Line-length histogram checker: follows every channel, predicts the histogram beats, compares.
module line_hist_checker
    import rqa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [31:0] row_bits
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,   // [5:0] line_length, [16:6] diagonal_count,
                                               // [27:17] vertical_count, [31:28] zero
    input  wire logic               m_tlast,   // last_bin
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [SIZE_W-1:0]  cfg_data,  // matrix_size
    output int                      mismatches,
    output int                      pending
);

    localparam int MAX_N = 32;
    localparam int DIAGS = 2 * MAX_N - 1;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [HIST_W-1:0] diag;
        logic [HIST_W-1:0] vert;
        logic              last;
    } bin_beat_t;

    bin_beat_t         bins_due[$];
    logic [SIZE_W-1:0] size_reg;
    int unsigned       rows_in;
    logic [LEN_W-1:0]  col_run [MAX_N];
    logic [LEN_W-1:0]  diag_run [DIAGS];
    logic [HIST_W-1:0] diag_hist [1:MAX_N];
    logic [HIST_W-1:0] vert_hist [1:MAX_N];
    int                errors;

    function automatic logic [HIST_W-1:0] bump_bin(input logic [HIST_W-1:0] h);
        return (h == HIST_MAX) ? h : h + 1'b1;
    endfunction

    function automatic void advance_run(input logic [LEN_W-1:0] run_in, input logic b,
                                        input logic ends, output logic [LEN_W-1:0] run_out,
                                        output logic [LEN_W-1:0] flushed);
        run_out = run_in;
        flushed = '0;
        if (b)
        begin
            if (run_out < MAX_N)
                run_out = run_out + 1'b1;
            if (ends)
            begin
                flushed = run_out;
                run_out = '0;
            end
        end
        else if (run_out != '0)
        begin
            flushed = run_out;
            run_out = '0;
        end
    endfunction

    task automatic clear_matrix();
        rows_in = 0;
        foreach (col_run[k])
            col_run[k] = '0;
        foreach (diag_run[k])
            diag_run[k] = '0;
        for (int k = 1; k <= MAX_N; k++)
        begin
            diag_hist[k] = '0;
            vert_hist[k] = '0;
        end
    endtask

    task automatic take_row(input logic [ROW_W-1:0] row);
        int unsigned      n;
        int unsigned      i;
        int unsigned      d;
        logic             last_row;
        logic [LEN_W-1:0] nr;
        logic [LEN_W-1:0] fl;
        bin_beat_t        b;
        n = (size_reg == 0) ? 1 : ((size_reg > MAX_N) ? MAX_N : size_reg);
        i = rows_in;
        last_row = (i == n - 1);
        for (int j = 0; j < n; j++)
        begin
            advance_run(col_run[j], row[j], last_row, nr, fl);
            col_run[j] = nr;
            if (fl != '0)
                vert_hist[fl] = bump_bin(vert_hist[fl]);
            d = i + n - 1 - j;
            advance_run(diag_run[d], row[j], last_row || (j == n - 1), nr, fl);
            diag_run[d] = nr;
            if (fl != '0)
                diag_hist[fl] = bump_bin(diag_hist[fl]);
        end
        if (!last_row)
            rows_in = i + 1;
        else
        begin
            for (int l = 1; l <= n; l++)
            begin
                b.len  = l;
                b.diag = diag_hist[l];
                b.vert = vert_hist[l];
                b.last = (l == n);
                bins_due.push_back(b);
            end
            clear_matrix();
        end
    endtask

    task automatic check_beat();
        bin_beat_t want;
        if (bins_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected histogram beat: tdata=%h tlast=%b", m_tdata, m_tlast);
        end
        else
        begin
            want = bins_due.pop_front();
            if (m_tdata[LEN_W-1:0] !== want.len
                || m_tdata[LEN_W +: HIST_W] !== want.diag
                || m_tdata[LEN_W + HIST_W +: HIST_W] !== want.vert
                || m_tdata[TDATA_W-1 -: PAD_W] !== '0
                || m_tlast !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("bin beat wrong: want len=%0d diag=%0d vert=%0d last=%b, got len=%0d diag=%0d vert=%0d pad=%h last=%b",
                             want.len, want.diag, want.vert, want.last,
                             m_tdata[LEN_W-1:0], m_tdata[LEN_W +: HIST_W],
                             m_tdata[LEN_W + HIST_W +: HIST_W], m_tdata[TDATA_W-1 -: PAD_W],
                             m_tlast);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg = 6'd32;
            clear_matrix();
            bins_due.delete();
            errors = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                size_reg = cfg_data;
                clear_matrix();
            end
            if (s_tvalid && s_tready)
                take_row(s_tdata);
            if (m_tvalid && m_tready)
                check_beat();
            mismatches <= errors;
            pending <= bins_due.size();
        end
    end

endmodule

/* tb/tb_recurrence_line_length_histogram_top.sv */
// Testbench top: clock, reset, row and size stimulus, output stalls, watchdog and verdict.
module tb_recurrence_line_length_histogram_top;
    import rqa_pkg::*;

    localparam int ROW_CYCLES  = 6 * 32 + 1;
    localparam int SETTLE      = ROW_CYCLES + 24;
    localparam int STALL_LIMIT = 4000;
    localparam int ROW_TARGET  = 450;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               m_tready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [SIZE_W-1:0]  cfg_data = '0;
    wire logic               s_tready;
    wire logic               m_tvalid;
    wire logic [TDATA_W-1:0] m_tdata;
    wire logic               m_tlast;
    wire logic               cfg_ready;
    int                 mismatches;
    int                 pending;
    logic               steady = 1'b0;
    int                 rows_sent = 0;
    int                 quiet_cycles = 0;
    logic [ROW_W-1:0]   prev_row = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    recurrence_line_length_histogram_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    line_hist_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    // mix of plain, dense, sparse, full, empty and shifted rows; shifting extends diagonals
    function automatic logic [ROW_W-1:0] pick_row();
        logic [ROW_W-1:0] r;
        case ($urandom_range(0, 6))
            0:       r = $urandom;
            1:       r = $urandom | $urandom;
            2:       r = $urandom & $urandom;
            3:       r = '1;
            4:       r = '0;
            default: r = {prev_row[ROW_W-2:0], 1'($urandom_range(0, 1))};
        endcase
        return r;
    endfunction

    task automatic send_row(input logic [ROW_W-1:0] row);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        rows_sent++;
        prev_row = row;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int gap;
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int                n;
        int                mats;
        int                cut;
        logic [SIZE_W-1:0] sz;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // partial matrix at the reset size, dropped by the next write
        send_row('1);
        send_row(32'h8000_0001);
        write_size(6'd1);
        send_row('0);
        send_row(32'hFFFF_FFFE);
        send_row(32'h0000_0001);
        write_size(6'd0);
        send_row('1);
        // oversize acts as the largest size; restart it mid-matrix
        write_size(6'd63);
        send_row(32'hAAAA_AAAA);
        send_row(32'h5555_5555);
        send_row('1);
        write_size(6'd3);
        repeat (3) send_row('1);
        send_row(32'h1);
        send_row(32'h2);
        send_row(32'h4);
        send_row(32'h4);
        send_row(32'h2);
        send_row(32'h1);
        repeat (3) send_row('0);
        write_size(6'd2);
        send_row(32'h1);
        send_row(32'h2);

        while (rows_sent < ROW_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       sz = 6'd32;
                1:       sz = 6'd1;
                2:       sz = 6'd2;
                3:       sz = $urandom_range(0, 1) ? 6'd63 : 6'd0;
                default: sz = $urandom_range(3, 12);
            endcase
            write_size(sz);
            n = (sz == 0) ? 1 : ((sz > 32) ? 32 : sz);
            mats = $urandom_range(1, 3);
            for (int m = 0; m < mats; m++)
                for (int r = 0; r < n; r++)
                    send_row(pick_row());
            if (n > 1 && $urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, n - 1);
                for (int r = 0; r < cut; r++)
                    send_row(pick_row());
            end
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
src/rqa_pkg.sv
src/rqa_step_unit.sv
src/rqa_vmem.sv
src/recurrence_line_length_histogram_top.sv
tb/line_hist_checker.sv
tb/tb_recurrence_line_length_histogram_top.sv
